// File: design/mwm_pkg.sv
// Shared types, constants and helper functions of the maze wall map unit.
`default_nettype none

package mwm_pkg;

  // Maze geometry.
  localparam int MAZE_SIZE = 16;
  localparam int WORD_W    = MAZE_SIZE;
  localparam int COORD_W   = 4;
  localparam int SAMPLE_W  = 12;
  localparam int NUM_WORDS = 2 * (MAZE_SIZE + 1);
  localparam int COL_BASE  = MAZE_SIZE + 1;
  localparam int ADDR_W    = $clog2(NUM_WORDS);

  localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_THR = 2'd3;

  localparam logic [SAMPLE_W-1:0] THR_RESET = 12'd1000;

  // Index of the last of the three sensor edges of a sense transaction.
  localparam logic [1:0] LAST_STEP = 2'd2;

  typedef enum logic [1:0] {
    REQ_SENSE = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    SIDE_N = 2'd0,
    SIDE_E = 2'd1,
    SIDE_S = 2'd2,
    SIDE_W = 2'd3
  } side_e;

  typedef enum logic [1:0] {
    MAP_MEAS = 2'd0,
    MAP_SRCH = 2'd1,
    MAP_VIS  = 2'd2
  } map_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_DONE
  } state_e;

  // One memory entry holds the same edge word of all three maps.
  typedef struct packed {
    logic [WORD_W-1:0] meas;
    logic [WORD_W-1:0] srch;
    logic [WORD_W-1:0] vis;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  // Contents of an entry after reset or after a clear transaction.
  // Row words live at addresses 0..MAZE_SIZE, column words after them.
  function automatic entry_t reset_entry(logic [ADDR_W-1:0] addr);
    entry_t            e;
    logic              is_col;
    logic [ADDR_W-1:0] idx;
    is_col = (addr >= ADDR_W'(COL_BASE));
    idx    = is_col ? (addr - ADDR_W'(COL_BASE)) : addr;
    e.srch = WORD_ONES;
    e.meas = '0;
    if ((idx == '0) || (idx == ADDR_W'(MAZE_SIZE))) begin
      e.meas = WORD_ONES;
    end else if (is_col && (idx == ADDR_W'(1))) begin
      e.meas = WORD_W'(1);
    end
    if (!is_col && (idx == ADDR_W'(1))) begin
      e.srch = WORD_ONES & ~WORD_W'(1);
    end
    e.vis = e.meas;
    return e;
  endfunction

  // Memory address of the word that holds one side of cell (x,y).
  function automatic logic [ADDR_W-1:0] edge_addr(logic [COORD_W-1:0] x,
                                                 logic [COORD_W-1:0] y,
                                                 side_e side);
    logic [ADDR_W-1:0] a;
    case (side)
      SIDE_N:  a = ADDR_W'(y) + ADDR_W'(1);
      SIDE_E:  a = ADDR_W'(COL_BASE) + ADDR_W'(x) + ADDR_W'(1);
      SIDE_S:  a = ADDR_W'(y);
      default: a = ADDR_W'(COL_BASE) + ADDR_W'(x);
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: design/mwm_store.sv
// Edge word memory of the three wall maps, with per-entry valid bits for fast clearing.
`default_nettype none

module mwm_store (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 clear_i,
  input  mwm_pkg::mem_rd_t    rd_i,
  input  mwm_pkg::mem_wr_t    wr_i,
  output mwm_pkg::entry_t     rd_data_o
);

  mwm_pkg::entry_t                 mem_q [mwm_pkg::NUM_WORDS];
  logic [mwm_pkg::NUM_WORDS-1:0]   valid_q;
  mwm_pkg::entry_t                 rd_word_q;
  logic                            rd_valid_q;
  logic [mwm_pkg::ADDR_W-1:0]      rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_word_q <= mem_q[rd_i.addr];
      rd_addr_q <= rd_i.addr;
    end
  end

  // An entry never written since the last clear reads as its reset contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_valid_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_word_q : mwm_pkg::reset_entry(rd_addr_q);

endmodule

`default_nettype wire

// File: design/maze_wall_map_update_query_unit.sv
// Top level of the maze wall map unit: configuration, sequencer and output register.
// Each sense edge is a memory read and a write-back; a clear or ignored transaction goes
// straight to completion. Only one transaction is in work at a time; the next is accepted
// in the same cycle as the result goes valid, and an output stall holds a finished
// transaction until its result is taken.
// Reset: thresholds go to 1000, updating is enabled and all maps read as their initial
// walls at once through the memory's valid bits; no clearing pass is needed.
`default_nettype none

module maze_wall_map_update_query_unit (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Configuration write channel.
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [mwm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [mwm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Request channel.
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire [1:0]                       req_type_i,
  input  wire [mwm_pkg::COORD_W-1:0]      cell_x_i,
  input  wire [mwm_pkg::COORD_W-1:0]      cell_y_i,
  input  wire [1:0]                       heading_i,
  input  wire [mwm_pkg::SAMPLE_W-1:0]     left_sample_i,
  input  wire [mwm_pkg::SAMPLE_W-1:0]     right_sample_i,
  input  wire [mwm_pkg::SAMPLE_W-1:0]     front_sample_i,
  input  wire [2:0]                       query_side_i,
  input  wire [1:0]                       map_select_i,
  // Result channel.
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic                            wall_present_o
);

  // The sequencer walks a sense transaction through its edges (left, right,
  // front), each as a read of the edge word followed by a write-back. A query reads
  // one word and picks the bit. Consecutive accesses never hit the same word in the
  // same cycle, so the memory needs no forwarding.
  mwm_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic                           update_en_q;
  logic [mwm_pkg::SAMPLE_W-1:0]   left_thr_q;
  logic [mwm_pkg::SAMPLE_W-1:0]   right_thr_q;
  logic [mwm_pkg::SAMPLE_W-1:0]   front_thr_q;

  // Transaction held while it is worked on.
  logic [1:0]                     req_q;
  logic [mwm_pkg::COORD_W-1:0]    x_q;
  logic [mwm_pkg::COORD_W-1:0]    y_q;
  logic [1:0]                     head_q;
  logic [mwm_pkg::SAMPLE_W-1:0]   ls_q;
  logic [mwm_pkg::SAMPLE_W-1:0]   rs_q;
  logic [mwm_pkg::SAMPLE_W-1:0]   fs_q;
  logic [1:0]                     qside_q;
  logic [1:0]                     sel_q;

  logic [1:0]                     step_q, step_d;
  logic                           result_q, result_d;
  logic                           out_valid_q;
  logic                           out_data_q;

  logic                           in_ready;
  logic                           load_out;
  logic                           store_clear;
  mwm_pkg::mem_rd_t               rd;
  mwm_pkg::mem_wr_t               wr;
  mwm_pkg::entry_t                rd_data;

  logic                           cell_ok;
  logic                           sel_ok;
  mwm_pkg::side_e                 step_side;
  mwm_pkg::side_e                 cur_side;
  logic [mwm_pkg::SAMPLE_W-1:0]   cur_sample;
  logic [mwm_pkg::SAMPLE_W-1:0]   cur_thr;
  logic                           wall_seen;
  logic [mwm_pkg::ADDR_W-1:0]     cur_addr;
  logic [mwm_pkg::WORD_W-1:0]     bit_mask;
  logic [mwm_pkg::WORD_W-1:0]     query_word;
  mwm_pkg::entry_t                new_entry;

  mwm_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (store_clear),
    .rd_i      (rd),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  // Configuration writes are always taken; the user must send them only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      update_en_q <= 1'b1;
      left_thr_q  <= mwm_pkg::THR_RESET;
      right_thr_q <= mwm_pkg::THR_RESET;
      front_thr_q <= mwm_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mwm_pkg::CFG_UPDATE_EN: update_en_q <= cfg_data_i[0];
        mwm_pkg::CFG_LEFT_THR:  left_thr_q  <= cfg_data_i;
        mwm_pkg::CFG_RIGHT_THR: right_thr_q <= cfg_data_i;
        mwm_pkg::CFG_FRONT_THR: front_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cells beyond the maze only exist for maze sizes below the coordinate range.
  assign cell_ok = (32'(cell_x_i) < 32'(mwm_pkg::MAZE_SIZE)) &&
                   (32'(cell_y_i) < 32'(mwm_pkg::MAZE_SIZE));
  assign sel_ok  = (map_select_i == mwm_pkg::MAP_MEAS) ||
                   (map_select_i == mwm_pkg::MAP_SRCH) ||
                   (map_select_i == mwm_pkg::MAP_VIS);

  // The step counter picks the sensor: left looks to heading plus three, right to
  // heading plus one, and front straight ahead.
  always_comb begin
    case (step_q)
      2'd0: begin
        step_side  = mwm_pkg::side_e'(head_q + 2'd3);
        cur_sample = ls_q;
        cur_thr    = left_thr_q;
      end
      2'd1: begin
        step_side  = mwm_pkg::side_e'(head_q + 2'd1);
        cur_sample = rs_q;
        cur_thr    = right_thr_q;
      end
      default: begin
        step_side  = mwm_pkg::side_e'(head_q);
        cur_sample = fs_q;
        cur_thr    = front_thr_q;
      end
    endcase
  end

  assign cur_side  = (req_q == mwm_pkg::REQ_QUERY) ? mwm_pkg::side_e'(qside_q) : step_side;
  assign wall_seen = cur_sample > cur_thr;
  assign cur_addr  = mwm_pkg::edge_addr(x_q, y_q, cur_side);
  assign bit_mask  = mwm_pkg::WORD_W'(1) <<
                     (((cur_side == mwm_pkg::SIDE_N) || (cur_side == mwm_pkg::SIDE_S)) ?
                      x_q : y_q);

  // A seen wall is set in the measured map, a free edge is opened in the search map,
  // and the visited map records the edge either way.
  always_comb begin
    new_entry = rd_data;
    if (wall_seen) begin
      new_entry.meas = rd_data.meas | bit_mask;
    end else begin
      new_entry.srch = rd_data.srch & ~bit_mask;
    end
    new_entry.vis = rd_data.vis | bit_mask;
  end

  always_comb begin
    case (sel_q)
      mwm_pkg::MAP_MEAS: query_word = rd_data.meas;
      mwm_pkg::MAP_SRCH: query_word = rd_data.srch;
      default:           query_word = rd_data.vis;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwm_pkg::ST_IDLE;
      step_q      <= '0;
      result_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      result_q <= result_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      req_q   <= req_type_i;
      x_q     <= cell_x_i;
      y_q     <= cell_y_i;
      head_q  <= heading_i;
      ls_q    <= left_sample_i;
      rs_q    <= right_sample_i;
      fs_q    <= front_sample_i;
      qside_q <= query_side_i[1:0];
      sel_q   <= map_select_i;
    end
    if (load_out) begin
      out_data_q <= result_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    result_d    = result_q;
    in_ready    = 1'b0;
    load_out    = 1'b0;
    store_clear = 1'b0;
    rd          = '0;
    wr          = '0;
    unique case (state_q)
      mwm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          step_d   = '0;
          result_d = 1'b0;
          state_d  = mwm_pkg::ST_DONE;
          case (req_type_i)
            mwm_pkg::REQ_SENSE: begin
              if (update_en_q && cell_ok) begin
                state_d = mwm_pkg::ST_READ;
              end
            end
            mwm_pkg::REQ_QUERY: begin
              if (cell_ok && sel_ok) begin
                state_d = mwm_pkg::ST_READ;
              end
            end
            mwm_pkg::REQ_CLEAR: store_clear = 1'b1;
            default: ;
          endcase
        end
      end
      mwm_pkg::ST_READ: begin
        rd.en   = 1'b1;
        rd.addr = cur_addr;
        state_d = mwm_pkg::ST_MODIFY;
      end
      mwm_pkg::ST_MODIFY: begin
        if (req_q == mwm_pkg::REQ_QUERY) begin
          result_d = |(query_word & bit_mask);
          state_d  = mwm_pkg::ST_DONE;
        end else begin
          wr.en   = 1'b1;
          wr.addr = cur_addr;
          wr.data = new_entry;
          step_d  = step_q + 2'd1;
          state_d = (step_q == mwm_pkg::LAST_STEP) ? mwm_pkg::ST_DONE : mwm_pkg::ST_READ;
        end
      end
      mwm_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = mwm_pkg::ST_IDLE;
        end
      end
      default: state_d = mwm_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o     = in_ready;
  assign out_valid_o    = out_valid_q;
  assign wall_present_o = out_data_q;

  // The memory is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(rd.en && wr.en))
    else $error("map memory read and write in the same cycle");

  // Every write-back follows a read of the same word in the previous cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   wr.en |-> ($past(rd.en) && ($past(rd.addr) == wr.addr)))
    else $error("map write-back without a matching read");

  // A clear finishes its transaction without touching the memory port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   store_clear |=> (state_q == mwm_pkg::ST_DONE))
    else $error("clear transaction did not go straight to completion");

endmodule

`default_nettype wire
